// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: queue depth,
// status codes, the entry held by a cell and the command broadcast to cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 32;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 4;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   after;
  } nb_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Compares its entry with the broadcast insert
// key and takes the new entry, its left neighbour's entry or its right
// neighbour's entry as the row opens or closes.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::nb_t   left_nb,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::nb_t   self_nb
);
  import spq_pkg::*;

  entry_t q;
  logic   after;

  // entry stays ahead of the new one: lower or equal priority number
  assign after   = q.valid && (q.prio <= cmd.prio);
  assign self_nb = '{ent: q, after: after};

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (cmd.ins) begin
      if (!after) begin
        if (left_nb.after) begin
          q <= '{valid: 1'b1, tag: cmd.tag, prio: cmd.prio};
        end else begin
          q <= left_nb.ent;
        end
      end
    end else if (cmd.rem) begin
      q <= right_ent;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   kind selects insert (job_tag, priority_req) or remove of the head entry.
//   A lower priority number is served first; equal numbers leave in arrival
//   order. busy stays low: every cell updates in the same cycle, so a new
//   command may follow in every cycle (one item per cycle).
//   Exactly one result beat follows each command, in the cycle after it, with
//   done high for that single cycle: status, the removed tag and priority
//   (zero unless a remove succeeded) and the occupancy after the command.
//   An insert into a full queue reports full, a remove from an empty queue
//   reports empty; the store is left as it was in both cases.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Synchronous reset empties the queue and clears every cell; no pending
//   result survives reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [spq_pkg::TAG_W-1:0]     job_tag,
  input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
  output logic                          done,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::TAG_W-1:0]     out_job_tag,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::OCC_W-1:0]     occupancy
);
  import spq_pkg::*;

  logic   accept;
  logic   full;
  logic   empty;
  count_t count;
  count_t count_next;
  cmd_t   cmd;
  nb_t    cell_nb [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == count_t'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  assign cmd.ins  = accept && (kind == KIND_INSERT) && !full;
  assign cmd.rem  = accept && (kind == KIND_REMOVE) && !empty;
  assign cmd.tag  = job_tag;
  assign cmd.prio = priority_req;

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + count_t'(1);
    end else if (cmd.rem) begin
      count_next = count - count_t'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    nb_t    left_nb;
    entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_nb = '{ent: '0, after: 1'b1};
    end else begin : g_mid
      assign left_nb = cell_nb[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_nb[i+1].ent;
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_nb   (left_nb),
      .right_ent (right_ent),
      .self_nb   (cell_nb[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      done         <= 1'b0;
      status       <= ST_INSERTED;
      out_job_tag  <= '0;
      out_priority <= '0;
      occupancy    <= '0;
    end else begin
      count <= count_next;
      done  <= accept;
      if (accept) begin
        occupancy    <= OCC_W'(count_next);
        out_job_tag  <= '0;
        out_priority <= '0;
        if (kind == KIND_INSERT) begin
          status <= full ? ST_FULL : ST_INSERTED;
        end else if (empty) begin
          status <= ST_EMPTY;
        end else begin
          status       <= ST_REMOVED;
          out_job_tag  <= cell_nb[0].ent.tag;
          out_priority <= cell_nb[0].ent.prio;
        end
      end
    end
  end

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cell_nb[0].ent.valid == (count != '0))
    else $error("head cell validity disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command beat without result beat");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    cell_nb[1].ent.valid |-> (cell_nb[0].ent.prio <= cell_nb[1].ent.prio))
    else $error("head entry out of priority order");

endmodule
